// File: hw/rtl/rrs_pkg.sv
// Shared types and constants for the round-robin scheduler with device wait queues.
`default_nettype none

package rrs_pkg;

  // Default number of processes tracked by the scheduler.
  localparam int unsigned DefNumProcs = 8;

  // Fixed widths of the transaction fields.
  localparam int unsigned OpW    = 2;
  localparam int unsigned ProcW  = 3;
  localparam int unsigned CountW = 4;

  // Highest value of the saturating termination counter.
  localparam logic [CountW-1:0] DoneMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 2'd0,
    OP_IO_DONE   = 2'd1,
    OP_BLOCK     = 2'd2,
    OP_TERMINATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_DONE    = 2'd3
  } proc_state_e;

  // Requests to one queue in a cycle.
  typedef struct packed {
    logic pop;
    logic push;
  } queue_ctrl_t;

endpackage : rrs_pkg

`default_nettype wire

// File: hw/rtl/rrs_ifs.sv
// Valid/ready channel interfaces for scheduler events and scheduler results.
`default_nettype none

interface rrs_evt_if;
  import rrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [ProcW-1:0]  proc;
  logic              device;

  modport source (output valid, output operation, output proc, output device, input ready);
  modport sink   (input valid, input operation, input proc, input device, output ready);
endinterface : rrs_evt_if

interface rrs_res_if;
  import rrs_pkg::*;

  logic               valid;
  logic               ready;
  logic               running_valid;
  logic [ProcW-1:0]   running_proc;
  logic               woken_valid;
  logic [ProcW-1:0]   woken_proc;
  logic [CountW-1:0]  ready_count;
  logic [CountW-1:0]  file_wait_count;
  logic [CountW-1:0]  dir_wait_count;
  logic [CountW-1:0]  done_count;

  modport source (
    output valid, output running_valid, output running_proc, output woken_valid,
    output woken_proc, output ready_count, output file_wait_count, output dir_wait_count,
    output done_count, input ready
  );
  modport sink (
    input valid, input running_valid, input running_proc, input woken_valid,
    input woken_proc, input ready_count, input file_wait_count, input dir_wait_count,
    input done_count, output ready
  );
endinterface : rrs_res_if

`default_nettype wire

// File: hw/rtl/rrs_queue.sv
// Circular FIFO of process indices with same-cycle pop and push.
`default_nettype none

module rrs_queue #(
  parameter int unsigned DEPTH   = rrs_pkg::DefNumProcs,
  parameter bit          PRELOAD = 1'b0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rrs_pkg::queue_ctrl_t         ctrl_i,
  input  wire logic [$clog2(DEPTH)-1:0]     wdata_i,
  output logic      [$clog2(DEPTH)-1:0]     head_o,
  output logic      [$clog2(DEPTH+1)-1:0]   fill_o,
  output logic      [$clog2(DEPTH+1)-1:0]   fill_next_o
);
  import rrs_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [IdxW-1:0] mem_q [DEPTH];
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW:0]   tail_sum;
  logic [IdxW-1:0] tail_idx;
  logic            push_ok;

  // A push into a full queue is dropped unless the same cycle frees the head slot.
  assign push_ok = ctrl_i.push && ((fill_q != CntW'(DEPTH)) || ctrl_i.pop);

  always_comb begin
    tail_sum = {1'b0, fill_q} + (CntW + 1)'(head_q);
    if (tail_sum >= (CntW + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (CntW + 1)'(DEPTH);
    end
    tail_idx = IdxW'(tail_sum);
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
      fill_d = fill_d - CntW'(1);
    end
    if (push_ok) begin
      fill_d = fill_d + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= PRELOAD ? CntW'(DEPTH - 1) : '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  if (PRELOAD) begin : g_preload
    // The queue starts out holding processes 1 through DEPTH-1 in order.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int unsigned i = 0; i < DEPTH; i++) begin
          mem_q[i] <= (i + 1 < DEPTH) ? IdxW'(i + 1) : '0;
        end
      end else if (push_ok) begin
        mem_q[tail_idx] <= wdata_i;
      end
    end
  end else begin : g_plain
    always_ff @(posedge clk_i) begin
      if (push_ok) begin
        mem_q[tail_idx] <= wdata_i;
      end
    end
  end

  assign head_o      = mem_q[head_q];
  assign fill_o      = fill_q;
  assign fill_next_o = fill_d;

endmodule : rrs_queue

`default_nettype wire

// File: hw/rtl/round_robin_scheduler_with_io_queues.sv
// Top level of the round-robin process scheduler with file and directory wait queues.
//
//   Channel  Dir  Payload                                           Accepted when
//   -------  ---  ------------------------------------------------  -------------------
//   evt_i    in   operation, proc, device                           valid && ready
//   res_o    out  running and woken process, queue and done counts  valid && ready
//
// Every event transaction produces exactly one result transaction.
// An event is captured in an input register, applied to the scheduler state by a
// single pass of combinational logic once the output register can take it, and its
// result is captured in the output register: one event per cycle while results drain.
// The output register only advances when it is empty or being drained, so a stalled
// result holds the input register, and the input register is refilled in the same
// cycle it is applied. Reset puts process 0 in the running state and queues the rest.
`default_nettype none

module round_robin_scheduler_with_io_queues #(
  parameter int unsigned NUM_PROCS = rrs_pkg::DefNumProcs
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrs_evt_if.sink   evt_i,
  rrs_res_if.source res_o
);
  import rrs_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_PROCS);
  localparam int unsigned CntW = $clog2(NUM_PROCS + 1);

  // Input register.
  logic             in_valid_q;
  logic [OpW-1:0]   op_q;
  logic [ProcW-1:0] proc_q;
  logic             dev_q;
  logic             advance;

  // Scheduler state.
  proc_state_e      status_q [NUM_PROCS];
  proc_state_e      status_d [NUM_PROCS];
  logic             cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [CountW-1:0] done_q, done_d;

  // Queue connections.
  queue_ctrl_t      rq_ctrl, fq_ctrl, dq_ctrl;
  logic [IdxW-1:0]  rq_wdata, wq_wdata;
  logic [IdxW-1:0]  rq_head, fq_head, dq_head;
  logic [CntW-1:0]  rq_fill, fq_fill, dq_fill;
  logic [CntW-1:0]  rq_fill_nx, fq_fill_nx, dq_fill_nx;

  // Per-event working values.
  logic [IdxW-1:0]  p_idx;
  logic             p_ok;
  logic             do_switch;
  logic             woke;
  logic [IdxW-1:0]  woken;
  logic [IdxW-1:0]  nxt;

  // Output register.
  logic               out_valid_q;
  logic               run_v_q, woke_v_q;
  logic [ProcW-1:0]   run_p_q, woke_p_q;
  logic [CountW-1:0]  rcnt_q, fcnt_q, dcnt_q, done_cnt_q;

  // The stored event is applied when the result register can take its result.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      op_q   <= evt_i.operation;
      proc_q <= evt_i.proc;
      dev_q  <= evt_i.device;
    end
  end

  // Process indices beyond the configured count are ignored by block and terminate.
  assign p_idx = IdxW'(proc_q);
  assign p_ok  = 32'(proc_q) < NUM_PROCS;

  rrs_queue #(.DEPTH(NUM_PROCS), .PRELOAD(1'b1)) u_ready_q (
    .clk_i, .rst_ni,
    .ctrl_i      (rq_ctrl),
    .wdata_i     (rq_wdata),
    .head_o      (rq_head),
    .fill_o      (rq_fill),
    .fill_next_o (rq_fill_nx)
  );

  rrs_queue #(.DEPTH(NUM_PROCS), .PRELOAD(1'b0)) u_file_q (
    .clk_i, .rst_ni,
    .ctrl_i      (fq_ctrl),
    .wdata_i     (wq_wdata),
    .head_o      (fq_head),
    .fill_o      (fq_fill),
    .fill_next_o (fq_fill_nx)
  );

  rrs_queue #(.DEPTH(NUM_PROCS), .PRELOAD(1'b0)) u_dir_q (
    .clk_i, .rst_ni,
    .ctrl_i      (dq_ctrl),
    .wdata_i     (wq_wdata),
    .head_o      (dq_head),
    .fill_o      (dq_fill),
    .fill_next_o (dq_fill_nx)
  );

  // Event handling. The statements are ordered so that later steps see the effect of
  // earlier ones, e.g. a terminate marks the process done before the switch looks at it.
  always_comb begin
    status_d    = status_q;
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    done_d      = done_q;
    rq_ctrl     = '0;
    fq_ctrl     = '0;
    dq_ctrl     = '0;
    rq_wdata    = '0;
    wq_wdata    = p_idx;
    do_switch   = 1'b0;
    woke        = 1'b0;
    woken       = '0;
    nxt         = '0;

    if (advance) begin
      unique case (op_e'(op_q))
        OP_TICK: begin
          do_switch = 1'b1;
        end
        OP_IO_DONE: begin
          // The head of the device queue is made ready whatever its status.
          if (dev_q && (dq_fill != '0)) begin
            dq_ctrl.pop = 1'b1;
            woken       = (32'(dq_head) < NUM_PROCS) ? dq_head : '0;
            woke        = 1'b1;
          end else if (!dev_q && (fq_fill != '0)) begin
            fq_ctrl.pop = 1'b1;
            woken       = (32'(fq_head) < NUM_PROCS) ? fq_head : '0;
            woke        = 1'b1;
          end
          if (woke) begin
            status_d[woken] = ST_READY;
            rq_ctrl.push    = 1'b1;
            rq_wdata        = woken;
          end
        end
        OP_BLOCK: begin
          if (p_ok) begin
            status_d[p_idx] = ST_BLOCKED;
            if (dev_q) begin
              dq_ctrl.push = 1'b1;
            end else begin
              fq_ctrl.push = 1'b1;
            end
            if (cur_valid_q && (cur_q == p_idx)) begin
              cur_valid_d = 1'b0;
            end
          end
        end
        OP_TERMINATE: begin
          if (p_ok && (status_q[p_idx] != ST_DONE)) begin
            status_d[p_idx] = ST_DONE;
            if (cur_valid_q && (cur_q == p_idx)) begin
              cur_valid_d = 1'b0;
            end
            if (done_q != DoneMax) begin
              done_d = done_q + CountW'(1);
            end
            do_switch = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Context switch: pop the ready head, requeue a still-running process, and run the
    // popped one only if it is still ready; a stale entry leaves nothing running.
    if (do_switch && (rq_fill != '0)) begin
      rq_ctrl.pop = 1'b1;
      nxt         = (32'(rq_head) < NUM_PROCS) ? rq_head : '0;
      if (cur_valid_d && (status_d[cur_d] == ST_RUNNING)) begin
        status_d[cur_d] = ST_READY;
        rq_ctrl.push    = 1'b1;
        rq_wdata        = cur_d;
      end
      if (status_d[nxt] == ST_READY) begin
        status_d[nxt] = ST_RUNNING;
        cur_valid_d   = 1'b1;
        cur_d         = nxt;
      end else begin
        cur_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_PROCS; i++) begin
        status_q[i] <= (i == 0) ? ST_RUNNING : ST_READY;
      end
      cur_valid_q <= 1'b1;
      cur_q       <= '0;
      done_q      <= '0;
    end else begin
      status_q    <= status_d;
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      done_q      <= done_d;
    end
  end

  // Result register: the result reflects the state after the event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      run_v_q    <= cur_valid_d;
      run_p_q    <= cur_valid_d ? ProcW'(cur_d) : '0;
      woke_v_q   <= woke;
      woke_p_q   <= woke ? ProcW'(woken) : '0;
      rcnt_q     <= CountW'(rq_fill_nx);
      fcnt_q     <= CountW'(fq_fill_nx);
      dcnt_q     <= CountW'(dq_fill_nx);
      done_cnt_q <= done_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.running_valid   = run_v_q;
  assign res_o.running_proc    = run_p_q;
  assign res_o.woken_valid     = woke_v_q;
  assign res_o.woken_proc      = woke_p_q;
  assign res_o.ready_count     = rcnt_q;
  assign res_o.file_wait_count = fcnt_q;
  assign res_o.dir_wait_count  = dcnt_q;
  assign res_o.done_count      = done_cnt_q;

  // A queue is never popped while empty.
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_ctrl.pop |-> rq_fill != '0) and (fq_ctrl.pop |-> fq_fill != '0) and
    (dq_ctrl.pop |-> dq_fill != '0))
    else $error("queue popped while empty");

  // An applied event always leaves a result in the output register.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("applied event produced no result");

  // Only an io completion can wake a process.
  a_wake_only_io : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (op_q != OP_IO_DONE)) |-> !woke)
    else $error("process woken by an event other than io completion");

  // The termination counter never goes down.
  a_done_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q >= $past(done_q))
    else $error("termination count decreased");

endmodule : round_robin_scheduler_with_io_queues

`default_nettype wire
